/* rtl/rrts_pkg.sv */
// Shared types and codes for the round-robin task scheduler
package rrts_pkg;

    // controller states
    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_CRE_SCAN,
        FSM_CRE_APPEND,
        FSM_SCHED,
        FSM_FINISH
    } fsm_t;

    // requested action codes
    typedef enum logic [1:0] {
        ACT_CREATE   = 2'd0,
        ACT_SCHEDULE = 2'd1,
        ACT_EXIT     = 2'd2,
        ACT_SLEEP    = 2'd3
    } action_t;

    // per-slot task state
    typedef enum logic [1:0] {
        TS_DEAD     = 2'd0,
        TS_READY    = 2'd1,
        TS_RUNNING  = 2'd2,
        TS_SLEEPING = 2'd3
    } task_state_t;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    localparam int TIME_W   = 32;
    localparam int ID_OUT_W = 4;

    // one task table entry as stored in memory
    typedef struct packed {
        task_state_t         state;
        logic [TIME_W-1:0]   wake;
    } slot_entry_t;

endpackage

/* rtl/round_robin_task_scheduler_unit.sv */
// Round-robin task table and scheduler, top level
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, action, now_seconds,  | into block
//          | sleep_seconds                             |
//  out     | out_valid, out_stall, status, created_id, | out of block
//          | previous_id, current_id                   |
//
// Task state and wake time live in one memory, scanned one slot per cycle through
// its single read port with write-back in the cycle after the read. Reset needs no
// clearing pass: slots at or above the count are never read, and slot 0 reads as
// running until first written. A new item is taken while a result still waits on
// a stalled output; the next result waits in the finish state.
module round_robin_task_scheduler_unit #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] now_seconds,
    input  logic [31:0] sleep_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  created_id,
    output logic [3:0]  previous_id,
    output logic [3:0]  current_id
);

    localparam int ID_W  = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int EXT_W = ID_W + rrts_pkg::ID_OUT_W;
    localparam int ENT_W = $bits(rrts_pkg::slot_entry_t);

    // low bits of a slot id for the result fields
    function automatic logic [rrts_pkg::ID_OUT_W-1:0] id_out(input logic [ID_W-1:0] id);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(id);
        return ext[rrts_pkg::ID_OUT_W-1:0];
    endfunction

    rrts_pkg::fsm_t            fsm_reg, fsm_next;
    rrts_pkg::action_t         act_reg, act_next;
    logic [31:0]               now_reg, now_next;
    logic [31:0]               wake_new_reg, wake_new_next;
    logic [ID_W-1:0]           prev_reg, prev_next;
    logic [ID_W-1:0]           running_reg, running_next;
    logic [CNT_W-1:0]          slots_reg, slots_next;
    logic [CNT_W-1:0]          iss_cnt_reg, iss_cnt_next;
    logic [ID_W-1:0]           addr_reg, addr_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]           pend_addr_reg, pend_addr_next;
    logic                      pend_last_reg, pend_last_next;
    logic                      found_reg, found_next;
    logic [1:0]                res_status_reg, res_status_next;
    logic [ID_W-1:0]           res_created_reg, res_created_next;
    logic                      s0_valid_reg, s0_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg, status_next;
    logic [3:0]                created_reg, created_next;
    logic [3:0]                previous_reg, previous_next;
    logic [3:0]                current_reg, current_next;

    logic                      wr_en;
    logic [ID_W-1:0]           wr_addr;
    rrts_pkg::slot_entry_t     wr_entry;
    logic                      rd_en;
    logic [ENT_W-1:0]          rd_data;
    rrts_pkg::slot_entry_t     rd_entry;
    rrts_pkg::slot_entry_t     cur_entry;
    logic                      runnable;

    // task table memory
    rrts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // slot 0 reads as running until first written
    always_comb
    begin
        rd_entry = rrts_pkg::slot_entry_t'(rd_data);
        if (pend_addr_reg == '0 && !s0_valid_reg)
        begin
            rd_entry.state = rrts_pkg::TS_RUNNING;
            rd_entry.wake  = '0;
        end
    end

    // entry as seen by the scheduler: exit or sleep on the old task, then wakeup
    always_comb
    begin
        cur_entry = rd_entry;
        if (pend_addr_reg == prev_reg && act_reg == rrts_pkg::ACT_EXIT)
        begin
            cur_entry.state = rrts_pkg::TS_DEAD;
        end
        else if (pend_addr_reg == prev_reg && act_reg == rrts_pkg::ACT_SLEEP)
        begin
            cur_entry.state = rrts_pkg::TS_SLEEPING;
            cur_entry.wake  = wake_new_reg;
        end
        if (cur_entry.state == rrts_pkg::TS_SLEEPING && cur_entry.wake <= now_reg)
        begin
            cur_entry.state = rrts_pkg::TS_READY;
        end
        runnable = cur_entry.state == rrts_pkg::TS_READY ||
                   cur_entry.state == rrts_pkg::TS_RUNNING;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= rrts_pkg::FSM_IDLE;
            running_reg    <= '0;
            slots_reg      <= CNT_W'(1);
            pend_valid_reg <= 1'b0;
            s0_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            running_reg    <= running_next;
            slots_reg      <= slots_next;
            pend_valid_reg <= pend_valid_next;
            s0_valid_reg   <= s0_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        now_reg         <= now_next;
        wake_new_reg    <= wake_new_next;
        prev_reg        <= prev_next;
        iss_cnt_reg     <= iss_cnt_next;
        addr_reg        <= addr_next;
        pend_addr_reg   <= pend_addr_next;
        pend_last_reg   <= pend_last_next;
        found_reg       <= found_next;
        res_status_reg  <= res_status_next;
        res_created_reg <= res_created_next;
        status_reg      <= status_next;
        created_reg     <= created_next;
        previous_reg    <= previous_next;
        current_reg     <= current_next;
    end

    // next state, memory access and datapath
    always_comb
    begin
        fsm_next         = fsm_reg;
        act_next         = act_reg;
        now_next         = now_reg;
        wake_new_next    = wake_new_reg;
        prev_next        = prev_reg;
        running_next     = running_reg;
        slots_next       = slots_reg;
        iss_cnt_next     = iss_cnt_reg;
        addr_next        = addr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        pend_last_next   = pend_last_reg;
        found_next       = found_reg;
        res_status_next  = res_status_reg;
        res_created_next = res_created_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        created_next     = created_reg;
        previous_next    = previous_reg;
        current_next     = current_reg;
        wr_en            = 1'b0;
        wr_addr          = pend_addr_reg;
        wr_entry         = cur_entry;
        rd_en            = 1'b0;

        case (fsm_reg)
            rrts_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    act_next         = rrts_pkg::action_t'(action);
                    now_next         = now_seconds;
                    wake_new_next    = now_seconds + sleep_seconds;
                    prev_next        = running_reg;
                    res_status_next  = rrts_pkg::STATUS_OK;
                    res_created_next = '0;
                    found_next       = 1'b0;
                    pend_valid_next  = 1'b0;
                    // scan starts after the running slot, wrapping at the count
                    iss_cnt_next     = '0;
                    if (CNT_W'(running_reg) == slots_reg - CNT_W'(1))
                    begin
                        addr_next = '0;
                    end
                    else
                    begin
                        addr_next = running_reg + ID_W'(1);
                    end
                    fsm_next = rrts_pkg::FSM_SCHED;
                    if (action == rrts_pkg::ACT_CREATE)
                    begin
                        addr_next    = ID_W'(1);
                        iss_cnt_next = CNT_W'(1);
                        if (slots_reg == CNT_W'(1))
                        begin
                            fsm_next = rrts_pkg::FSM_CRE_APPEND;
                        end
                        else
                        begin
                            fsm_next = rrts_pkg::FSM_CRE_SCAN;
                        end
                    end
                    else if (action != rrts_pkg::ACT_SCHEDULE && running_reg == '0)
                    begin
                        res_status_next = rrts_pkg::STATUS_REFUSED;
                        fsm_next        = rrts_pkg::FSM_FINISH;
                    end
                end
            end

            rrts_pkg::FSM_CRE_SCAN:
            begin
                // issue reads of slots 1 to count-1
                pend_valid_next = 1'b0;
                if (iss_cnt_reg < slots_reg)
                begin
                    rd_en           = 1'b1;
                    addr_next       = addr_reg + ID_W'(1);
                    iss_cnt_next    = iss_cnt_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_addr_next  = addr_reg;
                    pend_last_next  = iss_cnt_reg == slots_reg - CNT_W'(1);
                end
                // first dead slot is reused
                if (pend_valid_reg)
                begin
                    if (rd_entry.state == rrts_pkg::TS_DEAD)
                    begin
                        wr_en            = 1'b1;
                        wr_entry.state   = rrts_pkg::TS_READY;
                        wr_entry.wake    = '0;
                        res_created_next = pend_addr_reg;
                        pend_valid_next  = 1'b0;
                        fsm_next         = rrts_pkg::FSM_FINISH;
                    end
                    else if (pend_last_reg)
                    begin
                        pend_valid_next = 1'b0;
                        fsm_next        = rrts_pkg::FSM_CRE_APPEND;
                    end
                end
            end

            rrts_pkg::FSM_CRE_APPEND:
            begin
                // take the next unused slot if the table has room
                if (slots_reg == CNT_W'(MAX_TASKS))
                begin
                    res_status_next = rrts_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = ID_W'(slots_reg);
                    wr_entry.state   = rrts_pkg::TS_READY;
                    wr_entry.wake    = '0;
                    res_created_next = ID_W'(slots_reg);
                    slots_next       = slots_reg + CNT_W'(1);
                end
                fsm_next = rrts_pkg::FSM_FINISH;
            end

            rrts_pkg::FSM_SCHED:
            begin
                // issue reads around the ring, the old task last
                pend_valid_next = 1'b0;
                if (iss_cnt_reg < slots_reg)
                begin
                    rd_en           = 1'b1;
                    iss_cnt_next    = iss_cnt_reg + CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_addr_next  = addr_reg;
                    pend_last_next  = iss_cnt_reg == slots_reg - CNT_W'(1);
                    if (CNT_W'(addr_reg) == slots_reg - CNT_W'(1))
                    begin
                        addr_next = '0;
                    end
                    else
                    begin
                        addr_next = addr_reg + ID_W'(1);
                    end
                end
                // write back with wakeup, pick and demotion of the old task
                if (pend_valid_reg)
                begin
                    wr_en = 1'b1;
                    if (!found_reg && runnable)
                    begin
                        wr_entry.state = rrts_pkg::TS_RUNNING;
                        found_next     = 1'b1;
                        running_next   = pend_addr_reg;
                    end
                    else if (cur_entry.state == rrts_pkg::TS_RUNNING)
                    begin
                        wr_entry.state = rrts_pkg::TS_READY;
                    end
                    if (pend_last_reg)
                    begin
                        fsm_next = rrts_pkg::FSM_FINISH;
                    end
                end
            end

            rrts_pkg::FSM_FINISH:
            begin
                // hand the result to the output register once it is free
                pend_valid_next = 1'b0;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    created_next   = id_out(res_created_reg);
                    previous_next  = id_out(prev_reg);
                    current_next   = id_out(running_reg);
                    fsm_next       = rrts_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                fsm_next = rrts_pkg::FSM_IDLE;
            end
        endcase

        s0_valid_next = s0_valid_reg || (wr_en && wr_addr == '0);
    end

    // ports
    assign in_stall    = fsm_reg != rrts_pkg::FSM_IDLE;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign created_id  = created_reg;
    assign previous_id = previous_reg;
    assign current_id  = current_reg;

endmodule

/* rtl/rrts_ram.sv */
// Generic single-write, single-read RAM with registered read data
module rrts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the round-robin task scheduler unit
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_TASKS    = 16;
    localparam int IDLE_SLOT    = 0;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTED  = 40;
    localparam int DIR_ROWS     = 26;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] created;
        logic [3:0] prev;
        logic [3:0] cur;
    } sched_outcome_t;

    typedef struct packed {
        rrts_pkg::action_t act;
        logic [31:0]       now_s;
        logic [31:0]       dur;
        logic              typed;
        sched_outcome_t    res;
    } dir_row_t;

    localparam sched_outcome_t NO_OUTCOME = '0;

    // directed rows: reset behavior, filling the table, full table, sleep corner cases, slot reuse after exit
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{rrts_pkg::ACT_EXIT,     32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_REFUSED, 4'd0,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_SLEEP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{rrts_pkg::STATUS_REFUSED, 4'd0,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_SCHEDULE, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd0,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd1,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd2,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd3,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd4,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd5,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd6,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd7,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd8,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd9,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd10, 4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd11, 4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd12, 4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd13, 4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd14, 4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{rrts_pkg::STATUS_OK,      4'd15, 4'd0, 4'd0}},
        '{rrts_pkg::ACT_CREATE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{rrts_pkg::STATUS_FULL,    4'd0,  4'd0, 4'd0}},
        '{rrts_pkg::ACT_SCHEDULE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_OUTCOME},
        // wake time wraps below now, so the sleeper wakes in the same schedule
        '{rrts_pkg::ACT_SLEEP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_OUTCOME},
        // zero duration wakes at once
        '{rrts_pkg::ACT_SLEEP,    32'h0000_0000, 32'h0000_0000, 1'b0, NO_OUTCOME},
        '{rrts_pkg::ACT_SLEEP,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_OUTCOME},
        '{rrts_pkg::ACT_EXIT,     32'h0000_0000, 32'h0000_0000, 1'b0, NO_OUTCOME},
        // create reuses the slot freed by the exit
        '{rrts_pkg::ACT_CREATE,   32'h0000_0000, 32'h0000_0000, 1'b0, NO_OUTCOME},
        '{rrts_pkg::ACT_SCHEDULE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, NO_OUTCOME}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    rrts_pkg::action_t action;
    logic [31:0]       now_seconds;
    logic [31:0]       sleep_seconds;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [3:0]        created_id;
    logic [3:0]        previous_id;
    logic [3:0]        current_id;

    // predicted task table
    rrts_pkg::task_state_t slot_state [MAX_TASKS];
    logic [31:0]           slot_wake [MAX_TASKS];
    int                    run_slot;
    int                    live_count;

    sched_outcome_t awaited_outcomes [$];
    logic [31:0]    wall_clock;
    bit             gaps_on = 1'b1;
    bit             stalls_on = 1'b1;
    bit             long_hold_req = 1'b0;

    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int n_created = 0;
    int n_full = 0;
    int n_refused = 0;
    int n_switches = 0;
    int cycle_count = 0;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    round_robin_task_scheduler_unit #(
        .MAX_TASKS(MAX_TASKS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .now_seconds  (now_seconds),
        .sleep_seconds(sleep_seconds),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .created_id   (created_id),
        .previous_id  (previous_id),
        .current_id   (current_id)
    );

    // wake due sleepers, then rotate to the next runnable slot
    function automatic void rotate_to_next(logic [31:0] now_s);
        int  k;
        int  cand;
        int  prev;
        bit  found;
        prev  = run_slot;
        cand  = prev;
        found = 1'b0;
        for (k = 0; k < live_count; k++)
        begin
            if (slot_state[k] == rrts_pkg::TS_SLEEPING && slot_wake[k] <= now_s)
                slot_state[k] = rrts_pkg::TS_READY;
        end
        for (k = 0; k < live_count && !found; k++)
        begin
            cand = (cand + 1) % live_count;
            if (slot_state[cand] == rrts_pkg::TS_READY ||
                slot_state[cand] == rrts_pkg::TS_RUNNING)
                found = 1'b1;
        end
        if (found)
        begin
            if (slot_state[prev] == rrts_pkg::TS_RUNNING)
                slot_state[prev] = rrts_pkg::TS_READY;
            slot_state[cand] = rrts_pkg::TS_RUNNING;
            run_slot = cand;
        end
    endfunction

    // apply one action to the predicted table and return the outcome
    function automatic sched_outcome_t task_table_step(rrts_pkg::action_t act,
                                                       logic [31:0] now_s,
                                                       logic [31:0] dur);
        sched_outcome_t r;
        int             k;
        int             slot;
        r.status  = rrts_pkg::STATUS_OK;
        r.created = '0;
        r.prev    = 4'(run_slot);
        case (act)
            rrts_pkg::ACT_CREATE:
            begin
                // first dead slot below the count, else the next unused one
                slot = 0;
                for (k = 1; k < MAX_TASKS && slot == 0; k++)
                begin
                    if ((k < live_count && slot_state[k] == rrts_pkg::TS_DEAD) ||
                        k == live_count)
                        slot = k;
                end
                if (slot == 0)
                    r.status = rrts_pkg::STATUS_FULL;
                else
                begin
                    if (slot == live_count)
                        live_count++;
                    slot_state[slot] = rrts_pkg::TS_READY;
                    slot_wake[slot]  = '0;
                    r.created        = 4'(slot);
                end
            end
            rrts_pkg::ACT_SCHEDULE:
                rotate_to_next(now_s);
            default:
            begin
                if (run_slot == IDLE_SLOT)
                    r.status = rrts_pkg::STATUS_REFUSED;
                else
                begin
                    if (act == rrts_pkg::ACT_EXIT)
                        slot_state[run_slot] = rrts_pkg::TS_DEAD;
                    else
                    begin
                        slot_state[run_slot] = rrts_pkg::TS_SLEEPING;
                        slot_wake[run_slot]  = now_s + dur;
                    end
                    rotate_to_next(now_s);
                end
            end
        endcase
        r.cur = 4'(run_slot);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        // keep the log short when things go badly wrong
        if (mismatches <= MAX_PRINTED)
            $display("ERROR result %0d: %s got %0d want %0d", results_seen, what, got, want);
    endtask

    // offer one transfer on the input channel, called at a falling edge
    task automatic offer_item(rrts_pkg::action_t act, logic [31:0] now_s, logic [31:0] dur,
                              bit typed, sched_outcome_t typed_res);
        sched_outcome_t r;
        int             gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        now_seconds   <= now_s;
        sleep_seconds <= dur;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        r = task_table_step(act, now_s, dur);
        awaited_outcomes.push_back(typed ? typed_res : r);
        items_sent++;
        if (r.status == rrts_pkg::STATUS_FULL)
            n_full++;
        if (r.status == rrts_pkg::STATUS_REFUSED)
            n_refused++;
        if (act == rrts_pkg::ACT_CREATE && r.status == rrts_pkg::STATUS_OK)
            n_created++;
        if (r.prev != r.cur)
            n_switches++;
        @(negedge clk);
    endtask

    // random transfers with the given action mix
    task automatic random_phase(int n_items, int w_create, int w_sched, int w_exit,
                                int hold_at, logic [31:0] start_time);
        rrts_pkg::action_t act;
        logic [31:0]       now_s;
        logic [31:0]       dur;
        int                pick;
        int                i;
        wall_clock = start_time;
        for (i = 0; i < n_items; i++)
        begin
            if (i == hold_at)
                long_hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < w_create)
                act = rrts_pkg::ACT_CREATE;
            else if (pick < w_create + w_sched)
                act = rrts_pkg::ACT_SCHEDULE;
            else if (pick < w_create + w_sched + w_exit)
                act = rrts_pkg::ACT_EXIT;
            else
                act = rrts_pkg::ACT_SLEEP;
            // time mostly creeps forward, now and then it jumps anywhere
            if ($urandom_range(0, 9) == 0)
                now_s = $urandom();
            else
            begin
                wall_clock = wall_clock + $urandom_range(0, 5);
                now_s = wall_clock;
            end
            case ($urandom_range(0, 9))
                0:       dur = $urandom();
                1:       dur = 32'hFFFF_FFFF - $urandom_range(0, 15);
                default: dur = $urandom_range(0, 30);
            endcase
            offer_item(act, now_s, dur, 1'b0, NO_OUTCOME);
        end
    endtask

    // sender and end of run
    initial
    begin
        int i;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = rrts_pkg::ACT_CREATE;
        now_seconds   = '0;
        sleep_seconds = '0;
        for (i = 0; i < MAX_TASKS; i++)
        begin
            slot_state[i] = rrts_pkg::TS_DEAD;
            slot_wake[i]  = '0;
        end
        slot_state[IDLE_SLOT] = rrts_pkg::TS_RUNNING;
        run_slot   = IDLE_SLOT;
        live_count = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            offer_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].now_s, DIRECTED_ROWS[i].dur,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        // balanced mix, with one long output hold-off partway through
        random_phase(650, 35, 35, 15, 200, $urandom());

        // sender pauses until every result is back
        in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        @(negedge clk);

        // exit and sleep heavy, clock starting just below the wrap
        random_phase(550, 20, 30, 30, -1, 32'hFFFF_FF80);

        // back to back, no idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_phase(500, 30, 40, 15, -1, $urandom());
        in_valid <= 1'b0;

        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers: %0d tasks created, %0d creates on a full table",
                 items_sent, n_created, n_full);
        $display("%0d task switches, %0d exit/sleep refused for idle, %0d results checked",
                 n_switches, n_refused, results_seen);
        if (mismatches == 0)
            $display("round_robin_task_scheduler_unit: match");
        else
            $display("round_robin_task_scheduler_unit: mismatch");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (open_left > 0)
            begin
                open_left--;
                out_stall <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                open_left = $urandom_range(0, 9);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        sched_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (awaited_outcomes.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = awaited_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (created_id !== want.created)
                    report_mismatch("created_id", created_id, want.created);
                if (previous_id !== want.prev)
                    report_mismatch("previous_id", previous_id, want.prev);
                if (current_id !== want.cur)
                    report_mismatch("current_id", current_id, want.cur);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, awaited_outcomes.size());
            $display("round_robin_task_scheduler_unit: mismatch");
            $finish;
        end
    end

endmodule
